/* src/assert_macros.svh */
// Assertion helpers shared by the encoder RTL.
// Each check is sampled on the rising edge of aclk and is held off while
// aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// The expression must never be true at a sampled edge.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

/* src/b58_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-58 block encoder package
// Beat types, block descriptor, constants and the symbol and length tables.
// ----------------------------------------------------------------------------
package b58_pkg;

    localparam int BLOCK_BYTES     = 8;
    localparam int BLOCK_CHARS     = 11;
    localparam int RADIX           = 58;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Division by 58 handles a 22-bit dividend: a 6-bit remainder and a
    // 16-bit limb. The reciprocal is exact over that whole range.
    localparam int          LIMB_W   = 16;
    localparam int          DIVD_W   = 22;
    localparam int          RECIP_SH = 28;
    localparam int          RECIP_W  = 23;
    localparam int          PROD_W   = DIVD_W + RECIP_W;
    localparam logic [22:0] RECIP_58 = 23'd4628198;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [6:0] symbol;
        logic       last_of_block;
        logic       end_of_message;
    } out_beat_t;

    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  chars;
        logic        last;
    } blk_t;

    function automatic logic [3:0] chars_for_bytes(input logic [3:0] n);
        logic [3:0] c;
        case (n)
            4'd1:    c = 4'd2;
            4'd2:    c = 4'd3;
            4'd3:    c = 4'd5;
            4'd4:    c = 4'd6;
            4'd5:    c = 4'd7;
            4'd6:    c = 4'd9;
            4'd7:    c = 4'd10;
            4'd8:    c = 4'd11;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    // The alphabet is six contiguous ASCII runs once 0, I, O and l are left out.
    function automatic logic [6:0] b58_symbol(input logic [5:0] d);
        logic [6:0] s;
        if (d < 6'd9) begin
            s = 7'd49 + {1'b0, d};
        end else if (d < 6'd17) begin
            s = 7'd65 + {1'b0, d} - 7'd9;
        end else if (d < 6'd22) begin
            s = 7'd74 + {1'b0, d} - 7'd17;
        end else if (d < 6'd33) begin
            s = 7'd80 + {1'b0, d} - 7'd22;
        end else if (d < 6'd44) begin
            s = 7'd97 + {1'b0, d} - 7'd33;
        end else begin
            s = 7'd109 + {1'b0, d} - 7'd44;
        end
        return s;
    endfunction

endpackage

/* src/base58_block_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-58 block encoder
// Packs message bytes into 64-bit blocks and emits each block as base-58
// characters, most significant digit first, padded with leading '1'.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one message byte per beat; last_byte closes a partial block.
//   m_ channel: one ASCII character per beat, with last_of_block on the final
//   character of each block and end_of_message on the final one of a message.
//   A full block gives 11 characters; a partial block of n bytes gives 2, 3,
//   5, 6, 7, 9 or 10 characters for n from 1 to 7.
//   Bytes are taken one per cycle while the block queue has room. A closed
//   block occupies the digit engine while the shared divide-by-58 unit works
//   out its characters, one 16-bit limb a cycle, and then while they are
//   sent, one character per cycle while the receiver takes them.
//   When the receiver stalls, the output register holds its character, the
//   engine waits, the queue fills and s_ready falls until room frees up.
//   Synchronous reset clears the packer, empties the queue and drops any
//   character not yet taken.
// ----------------------------------------------------------------------------
module base58_block_encoder
    import b58_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic push_valid, push_ready;
    blk_t push_data;
    logic pop_valid, pop_ready;
    blk_t pop_data;

    b58_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    b58_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b58_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* src/b58_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-58 block queue
// Small first-in first-out store of block descriptors between the packer
// and the digit engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b58_queue
    import b58_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  blk_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output blk_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    blk_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_NEVER(a_q_count_range, cnt_reg > CNT_W'(DEPTH), "queue fill count out of range")
    `ASSERT_CLK(a_q_fill_step, (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1),
                "queue fill count did not follow a lone push")

endmodule

/* src/b58_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-58 byte packer
// Accepts message bytes, packs them big-endian and hands closed blocks,
// with their character count, to the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b58_front
    import b58_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    output logic     push_valid,
    input  logic     push_ready,
    output blk_t     push_data
);

    logic [63:0] value_reg, value_next;
    logic [2:0]  held_reg, held_next;
    logic [63:0] packed_value;
    logic [3:0]  new_count;
    logic        accept, flush;

    assign s_ready      = push_ready;
    assign accept       = s_valid && s_ready;
    assign packed_value = {value_reg[55:0], s_data.data_byte};
    assign new_count    = {1'b0, held_reg} + 4'd1;
    assign flush        = (new_count == 4'(BLOCK_BYTES)) || s_data.last_byte;

    assign push_valid      = s_valid && flush;
    assign push_data.value = packed_value;
    assign push_data.chars = chars_for_bytes(new_count);
    assign push_data.last  = s_data.last_byte;

    always_comb begin
        value_next = value_reg;
        held_next  = held_reg;
        if (accept) begin
            if (flush) begin
                value_next = '0;
                held_next  = '0;
            end else begin
                value_next = packed_value;
                held_next  = new_count[2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            held_reg  <= '0;
        end else begin
            value_reg <= value_next;
            held_reg  <= held_next;
        end
    end

    `ASSERT_CLK(a_fr_flush_clears, (accept && flush) |=> (held_reg == 3'd0),
                "packer kept bytes after a block was closed")
    `ASSERT_CLK(a_fr_byte_counts, (accept && !flush) |=> (held_reg == $past(held_reg) + 3'd1),
                "packer byte count did not advance")

endmodule

/* src/b58_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-58 digit engine
// Takes one block at a time, divides it by 58 one 16-bit limb a cycle to get
// its digits, then sends the symbols out most significant first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b58_back
    import b58_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  blk_t      pop_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [63:0]       num_reg, num_next;
    logic [5:0]        rem_reg, rem_next;
    logic [1:0]        limb_reg, limb_next;
    logic [3:0]        pos_reg, pos_next;
    logic [3:0]        idx_reg, idx_next;
    logic [3:0]        chars_reg, chars_next;
    logic              last_reg, last_next;
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_data_reg;
    logic [5:0]        digit_store [BLOCK_CHARS];

    logic [DIVD_W-1:0] dividend;
    logic [PROD_W-1:0] prod;
    logic [15:0]       quot;
    logic [DIVD_W-1:0] quot58;
    logic [5:0]        digit;
    logic              store_digit;
    logic              out_free;
    logic              final_char;
    logic              emit_char;

    assign dividend = {rem_reg, num_reg[63:48]};
    assign prod     = PROD_W'(dividend) * PROD_W'(RECIP_58);
    assign quot     = prod[RECIP_SH +: LIMB_W];
    assign quot58   = {1'b0, quot, 5'd0} + {2'd0, quot, 4'd0} + {3'd0, quot, 3'd0}
                    + {5'd0, quot, 1'd0};
    assign digit    = 6'(dividend - quot58);

    assign pop_ready   = (state_reg == ST_IDLE);
    assign out_free    = !m_valid_reg || m_ready;
    assign final_char  = (idx_reg == chars_reg - 4'd1);
    assign store_digit = (state_reg == ST_DIV) && (limb_reg == 2'd3);
    assign emit_char   = (state_reg == ST_EMIT) && out_free;
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        limb_next    = limb_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        chars_next   = chars_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    num_next   = pop_data.value;
                    chars_next = pop_data.chars;
                    last_next  = pop_data.last;
                    pos_next   = pop_data.chars - 4'd1;
                    rem_next   = '0;
                    limb_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                num_next  = {num_reg[47:0], quot};
                limb_next = limb_reg + 2'd1;
                rem_next  = digit;
                if (limb_reg == 2'd3) begin
                    rem_next = '0;
                    if (pos_reg == 4'd0) begin
                        idx_next   = '0;
                        state_next = ST_EMIT;
                    end else begin
                        pos_next = pos_reg - 4'd1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    idx_next     = idx_reg + 4'd1;
                    if (final_char) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        limb_reg   <= limb_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        chars_reg  <= chars_next;
        last_reg   <= last_next;
        if (emit_char) begin
            m_data_reg.symbol         <= b58_symbol(digit_store[idx_reg]);
            m_data_reg.last_of_block  <= final_char;
            m_data_reg.end_of_message <= final_char && last_reg;
        end
        if (store_digit) begin
            digit_store[pos_reg] <= digit;
        end
    end

    `ASSERT_CLK(a_bk_rem_range, (state_reg == ST_DIV) |-> (rem_reg < 6'(RADIX)),
                "partial remainder reached the radix")
    `ASSERT_CLK(a_bk_eom_on_last, (m_valid && m_data.end_of_message) |-> m_data.last_of_block,
                "end of message flagged away from the end of a block")

endmodule
